### design/rcwd_pkg.sv
// ----------------------------------------------------------------------------
// RC output failsafe watchdog: shared package
// Types, field widths and constants shared by the front end, the queue and
// the back end of the watchdog.
// ----------------------------------------------------------------------------
package rcwd_pkg;

  localparam int IN_CH        = 4;
  localparam int DEF_CHANNELS = 4;
  localparam int CMD_W        = 16;
  localparam int PULSE_W      = 11;
  localparam int BITS_W       = 4;
  localparam int MASK_W       = 8;
  localparam int TONE_W       = 16;
  localparam int TMO_W        = 16;
  localparam int EVT_W        = 32;
  localparam int Q_DEPTH      = 2;
  localparam int IN_TDATA_W   = 96;
  localparam int OUT_TDATA_W  = 104;

  localparam logic signed [CMD_W-1:0] CMD_MIN     = -16'sd1000;
  localparam logic signed [CMD_W-1:0] CMD_MAX     = 16'sd1000;
  localparam logic [PULSE_W-1:0]      PULSE_MID   = 11'd1500;
  localparam logic [BITS_W-1:0]       BITS_MASK   = 4'hf;
  localparam logic [TMO_W-1:0]        TIMEOUT_RST = 16'd1000;

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_FORCE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                             op;
    logic [IN_CH-1:0][PULSE_W-1:0]   pulse;
    logic [BITS_W-1:0]               bits;
    logic [TONE_W-1:0]               tone;
    logic                            force_en;
  } item_t;

endpackage

### design/rc_output_failsafe_watchdog.sv
// ----------------------------------------------------------------------------
// RC output failsafe watchdog: top level
// An accepted item is written into the queue and then executed into the back
// end state registers; one item per cycle is sustained when out_tready holds.
// A two-entry queue sits between the decode front end and the state back
// end, so input items are taken while a finished result waits.
// Reset (synchronous, active low) forces failsafe with safe outputs and a
// timeout of 1000 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_output_failsafe_watchdog
  import rcwd_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [TMO_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd_ch0, cmd_ch1, cmd_ch2, cmd_ch3, out_mask_in, tone_hz_in, force_enable
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pulse_ch0, pulse_ch1, pulse_ch2, pulse_ch3, out_bits, tone_hz,
  // failsafe_now, failsafe_events
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PAD_W = OUT_TDATA_W - IN_CH*PULSE_W - BITS_W - TONE_W - 1 - EVT_W;

  logic                          q_full;
  logic                          q_push;
  item_t                         push_item;
  logic                          q_pop;
  logic                          head_valid;
  item_t                         head_item;
  logic [IN_CH-1:0][PULSE_W-1:0] res_pulse;
  logic [BITS_W-1:0]             res_bits;
  logic [TONE_W-1:0]             res_tone;
  logic                          res_failsafe;
  logic [EVT_W-1:0]              res_events;

  rcwd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  rcwd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  rcwd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (head_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .res_pulse    (res_pulse),
    .res_bits     (res_bits),
    .res_tone     (res_tone),
    .res_failsafe (res_failsafe),
    .res_events   (res_events)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_events, res_failsafe, res_tone, res_bits, res_pulse};

endmodule

### design/rcwd_front.sv
// ----------------------------------------------------------------------------
// RC output failsafe watchdog: front end
// Accepts input items, decodes the opcode and turns each raw channel command
// into its clamped pulse width before the item enters the queue.
// ----------------------------------------------------------------------------
module rcwd_front
  import rcwd_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  function automatic logic [PULSE_W-1:0] cmd_to_pulse(input logic signed [CMD_W-1:0] v);
    logic signed [CMD_W-1:0]   cl;
    logic signed [PULSE_W-1:0] c11;
    logic signed [PULSE_W-1:0] adj;
    logic signed [PULSE_W-1:0] half;
    logic [PULSE_W:0]          sum;
    if (v < CMD_MIN) begin
      cl = CMD_MIN;
    end else if (v > CMD_MAX) begin
      cl = CMD_MAX;
    end else begin
      cl = v;
    end
    c11  = cl[PULSE_W-1:0];
    adj  = c11 + $signed({{(PULSE_W-1){1'b0}}, c11[PULSE_W-1]});
    half = adj >>> 1;
    sum  = {1'b0, PULSE_MID} + {half[PULSE_W-1], half};
    return sum[PULSE_W-1:0];
  endfunction

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.op = op_t'(in_tuser);
    for (int c = 0; c < IN_CH; c++) begin
      q_item.pulse[c] = cmd_to_pulse($signed(in_tdata[c*CMD_W +: CMD_W]));
    end
    q_item.bits     = in_tdata[IN_CH*CMD_W +: BITS_W] & BITS_MASK;
    q_item.tone     = in_tdata[IN_CH*CMD_W+MASK_W +: TONE_W];
    q_item.force_en = in_tdata[IN_CH*CMD_W+MASK_W+TONE_W];
  end

endmodule

### design/rcwd_queue.sv
// ----------------------------------------------------------------------------
// RC output failsafe watchdog: item queue
// A short first-in first-out queue of decoded items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module rcwd_queue
  import rcwd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(Q_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(Q_DEPTH - 1);

  item_t         mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == DEPTH_C);
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/rcwd_back.sv
// ----------------------------------------------------------------------------
// RC output failsafe watchdog: back end
// Executes queued items against the watchdog state: stored command, driven
// outputs, silence counter, failsafe flag and event count. The driven state
// registers, failsafe flag and event count are the result payload.
// ----------------------------------------------------------------------------
module rcwd_back
  import rcwd_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [TMO_W-1:0]              cfg_wr_data,
  input  logic                          q_valid,
  input  item_t                         q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [IN_CH-1:0][PULSE_W-1:0] res_pulse,
  output logic [BITS_W-1:0]             res_bits,
  output logic [TONE_W-1:0]             res_tone,
  output logic                          res_failsafe,
  output logic [EVT_W-1:0]              res_events
);

  localparam int NUM_DRV = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;

  logic [TMO_W-1:0]   timeout_r;
  logic [PULSE_W-1:0] st_pulse_r  [NUM_DRV];
  logic [PULSE_W-1:0] st_pulse_nxt[NUM_DRV];
  logic [BITS_W-1:0]  st_bits_r, st_bits_nxt;
  logic [TONE_W-1:0]  st_tone_r, st_tone_nxt;
  logic [PULSE_W-1:0] drv_pulse_r  [NUM_DRV];
  logic [PULSE_W-1:0] drv_pulse_nxt[NUM_DRV];
  logic [BITS_W-1:0]  drv_bits_r, drv_bits_nxt;
  logic [TONE_W-1:0]  drv_tone_r, drv_tone_nxt;
  logic [TMO_W-1:0]   silence_r, silence_nxt;
  logic               forced_r, forced_nxt;
  logic               fs_r, fs_nxt;
  logic [EVT_W-1:0]   events_r, events_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TMO_W-1:0]   sil_inc;
  logic               fs_tick;

  assign q_pop   = q_valid && (!out_valid_r || out_tready);
  assign sil_inc = (silence_r < timeout_r) ? silence_r + 1'b1 : silence_r;
  assign fs_tick = forced_r || (sil_inc >= timeout_r);

  always_comb begin
    st_pulse_nxt  = st_pulse_r;
    st_bits_nxt   = st_bits_r;
    st_tone_nxt   = st_tone_r;
    drv_pulse_nxt = drv_pulse_r;
    drv_bits_nxt  = drv_bits_r;
    drv_tone_nxt  = drv_tone_r;
    silence_nxt   = silence_r;
    forced_nxt    = forced_r;
    fs_nxt        = fs_r;
    events_nxt    = events_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      case (q_item.op)
        OP_CMD: begin
          silence_nxt = '0;
          for (int c = 0; c < NUM_DRV; c++) begin
            st_pulse_nxt[c]  = q_item.pulse[c];
            drv_pulse_nxt[c] = forced_r ? PULSE_MID : q_item.pulse[c];
          end
          st_bits_nxt  = q_item.bits;
          st_tone_nxt  = q_item.tone;
          drv_bits_nxt = forced_r ? '0 : q_item.bits;
          drv_tone_nxt = forced_r ? '0 : q_item.tone;
        end
        OP_FORCE: begin
          forced_nxt = q_item.force_en;
          if (q_item.force_en) begin
            for (int c = 0; c < NUM_DRV; c++) begin
              st_pulse_nxt[c]  = PULSE_MID;
              drv_pulse_nxt[c] = PULSE_MID;
            end
            st_bits_nxt  = '0;
            st_tone_nxt  = '0;
            drv_bits_nxt = '0;
            drv_tone_nxt = '0;
          end else if (forced_r && (silence_r < timeout_r)) begin
            drv_pulse_nxt = st_pulse_r;
            drv_bits_nxt  = st_bits_r;
            drv_tone_nxt  = st_tone_r;
          end
        end
        OP_TICK: begin
          silence_nxt = sil_inc;
          fs_nxt      = fs_tick;
          if (fs_tick) begin
            for (int c = 0; c < NUM_DRV; c++) begin
              st_pulse_nxt[c]  = PULSE_MID;
              drv_pulse_nxt[c] = PULSE_MID;
            end
            st_bits_nxt  = '0;
            st_tone_nxt  = '0;
            drv_bits_nxt = '0;
            drv_tone_nxt = '0;
          end
          if (fs_tick && !fs_r) begin
            events_nxt = events_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      for (int c = 0; c < NUM_DRV; c++) begin
        st_pulse_r[c]  <= PULSE_MID;
        drv_pulse_r[c] <= PULSE_MID;
      end
      st_bits_r   <= '0;
      st_tone_r   <= '0;
      drv_bits_r  <= '0;
      drv_tone_r  <= '0;
      silence_r   <= '0;
      forced_r    <= 1'b1;
      fs_r        <= 1'b1;
      events_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      st_pulse_r  <= st_pulse_nxt;
      st_bits_r   <= st_bits_nxt;
      st_tone_r   <= st_tone_nxt;
      drv_pulse_r <= drv_pulse_nxt;
      drv_bits_r  <= drv_bits_nxt;
      drv_tone_r  <= drv_tone_nxt;
      silence_r   <= silence_nxt;
      forced_r    <= forced_nxt;
      fs_r        <= fs_nxt;
      events_r    <= events_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar c = 0; c < IN_CH; c++) begin : g_res
    if (c < NUM_DRV) begin : g_drv
      assign res_pulse[c] = drv_pulse_r[c];
    end else begin : g_mid
      assign res_pulse[c] = PULSE_MID;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign res_bits     = drv_bits_r;
  assign res_tone     = drv_tone_r;
  assign res_failsafe = fs_r;
  assign res_events   = events_r;

  a_forced_safe: assert property (@(posedge clk) disable iff (!rst_n)
    forced_r |-> (drv_bits_r == '0) && (drv_tone_r == '0) && (res_pulse[0] == PULSE_MID))
    else $error("forced failsafe is set but outputs are not safe");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(events_r) && $stable(drv_bits_r) && $stable(drv_tone_r)
               && $stable(silence_r))
    else $error("watchdog state changed without an item");

  a_event_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.op == OP_TICK) && fs_tick && !fs_r) |=> (events_r == $past(events_r) + 1'b1))
    else $error("failsafe rising edge was not counted");

  a_cmd_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.op == OP_CMD)) |=> (silence_r == '0))
    else $error("command did not restart the silence counter");

endmodule
